[hw/rtl/tea16_chained_block_decrypt_top_macros.svh]
// assertion macros shared by the decrypt block modules
`ifndef TEA16_CHAINED_BLOCK_DECRYPT_TOP_MACROS_SVH
`define TEA16_CHAINED_BLOCK_DECRYPT_TOP_MACROS_SVH

// property checked at every clock edge outside reset
`define TCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define TCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tcbd_pkg.sv]
// types and constants of the chained tea block decrypt
package tcbd_pkg;

  localparam int unsigned TcbdRounds = 16;
  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] TeaDelta   = 32'h9E3779B9;
  localparam logic [3:0]  HeaderFixed = 4'd3;
  localparam logic [3:0]  BlockBytes  = 4'd8;

  // configuration register indexes
  localparam logic [1:0] CfgKeyWord0 = 2'd0;
  localparam logic [1:0] CfgKeyWord1 = 2'd1;
  localparam logic [1:0] CfgKeyWord2 = 2'd2;
  localparam logic [1:0] CfgKeyWord3 = 2'd3;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StShort  = 2'd1,
    StBadPad = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle   = 3'b001,
    SRun    = 3'b010,
    SFinish = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [63:0] cipher;
    logic        last;
    logic        first;
  } blk_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } key_t;

endpackage

[hw/rtl/tcbd_in_if.sv]
// input channel: cipher blocks
interface tcbd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_block;
  logic        last_block;

  modport source (output valid, output cipher_block, output last_block, input ready);
  modport sink   (input valid, input cipher_block, input last_block, output ready);
endinterface

[hw/rtl/tcbd_out_if.sv]
// output channel: plaintext results
interface tcbd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_bytes;
  logic [7:0]  byte_valid;
  logic        end_of_message;
  logic [1:0]  status;

  modport source (output valid, output plain_bytes, output byte_valid,
                  output end_of_message, output status, input ready);
  modport sink   (input valid, input plain_bytes, input byte_valid,
                  input end_of_message, input status, output ready);
endinterface

[hw/rtl/tcbd_front.sv]
// front end: accepts blocks, marks message starts, queues them
`include "tea16_chained_block_decrypt_top_macros.svh"

module tcbd_front import tcbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  tcbd_in_if.sink  blk_i,
  output logic     q_valid_o,
  output blk_t     q_item_o,
  input  logic     q_pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  blk_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_msg_q, in_msg_d;
  logic            push;
  blk_t            wr_item;

  assign blk_i.ready = (cnt_q != CntW'(QueueDepth));
  assign push        = blk_i.valid && blk_i.ready;
  assign q_valid_o   = (cnt_q != '0);
  assign q_item_o    = mem_q[rptr_q];

  // first block of a message is the one after a last block or after reset
  assign wr_item.cipher = blk_i.cipher_block;
  assign wr_item.last   = blk_i.last_block;
  assign wr_item.first  = !in_msg_q;

  always_comb begin
    wptr_d   = wptr_q;
    rptr_d   = rptr_q;
    cnt_d    = cnt_q;
    in_msg_d = in_msg_q;
    if (push) begin
      wptr_d   = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      in_msg_d = !blk_i.last_block;
    end
    if (q_pop_i) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      rptr_q   <= '0;
      cnt_q    <= '0;
      in_msg_q <= 1'b0;
    end else begin
      wptr_q   <= wptr_d;
      rptr_q   <= rptr_d;
      cnt_q    <= cnt_d;
      in_msg_q <= in_msg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_item;
    end
  end

  `TCBD_ASSERT(a_cnt_bound, cnt_q <= CntW'(QueueDepth), "queue count beyond depth")
  `TCBD_ASSERT(a_pop_nonempty, !q_pop_i || (cnt_q != '0), "pop from empty queue")
  `TCBD_ASSERT_NEXT(a_last_resets_msg, push && blk_i.last_block, !in_msg_q,
                    "message flag not cleared after last block")

endmodule

[hw/rtl/tcbd_back.sv]
// back end: iterative tea decipher, chaining and result classification
`include "tea16_chained_block_decrypt_top_macros.svh"

module tcbd_back import tcbd_pkg::*; #(
  parameter int unsigned ROUNDS = TcbdRounds
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  key_t       key_i,
  input  logic       q_valid_i,
  input  blk_t       q_item_i,
  output logic       q_pop_o,
  tcbd_out_if.source res_o
);

  localparam int unsigned RndW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [63:0] SumProd = 64'(TeaDelta) * 64'(ROUNDS);
  localparam logic [31:0] SumInit = SumProd[31:0];

  back_state_e     state_q, state_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic [31:0]     y_q, y_d, z_q, z_d, sum_q, sum_d;
  logic [31:0]     y_n, z_n;
  logic [63:0]     cur_cipher_q;
  logic            cur_last_q, cur_first_q;
  logic [63:0]     chain_q, chain_d, prev_q, prev_d;
  logic [3:0]      hdr_left_q, hdr_left_d;

  logic            out_valid_q, out_valid_d;
  logic [63:0]     out_plain_q;
  logic [7:0]      out_bv_q;
  logic            out_eom_q;
  status_e         out_st_q;

  logic [63:0]     dec, plain, chain_src, start_blk;
  logic [3:0]      hdr, skip;
  logic [7:0]      bv;
  status_e         st;
  logic            slot_free, fin_load, start;

  // one round: z half then y half
  assign z_n = z_q - (((y_q << 4) + key_i.w2) ^ (y_q + sum_q) ^ ((y_q >> 5) + key_i.w3));
  assign y_n = y_q - (((z_n << 4) + key_i.w0) ^ (z_n + sum_q) ^ ((z_n >> 5) + key_i.w1));

  assign dec   = {y_q, z_q};
  assign plain = dec ^ prev_q;

  always_comb begin
    hdr  = cur_first_q ? ({1'b0, plain[58:56]} + HeaderFixed) : hdr_left_q;
    skip = (hdr > BlockBytes) ? BlockBytes : hdr;
    bv   = 8'hFF >> skip;
    st   = StOk;
    if (cur_last_q) begin
      bv = bv & 8'h80;
      if (cur_first_q || (skip > 4'd1)) begin
        st = StShort;
      end else if (plain[55:0] != '0) begin
        st = StBadPad;
      end
    end
    if (st != StOk) begin
      bv = '0;
    end
  end

  assign slot_free = !out_valid_q || res_o.ready;
  assign fin_load  = (state_q == SFinish) && slot_free;
  assign start     = q_valid_i && ((state_q == SIdle) || fin_load);
  assign q_pop_o   = start;

  // chain value the next block sees
  assign chain_src = (state_q == SFinish) ? (cur_last_q ? '0 : dec) : chain_q;
  assign start_blk = q_item_i.cipher ^ chain_src;

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    y_d        = y_q;
    z_d        = z_q;
    sum_d      = sum_q;
    chain_d    = chain_q;
    prev_d     = prev_q;
    hdr_left_d = hdr_left_q;
    unique case (state_q)
      SIdle: begin
      end
      SRun: begin
        y_d   = y_n;
        z_d   = z_n;
        sum_d = sum_q - TeaDelta;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RndW'(ROUNDS - 1)) begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        if (fin_load) begin
          state_d = SIdle;
          if (cur_last_q) begin
            chain_d    = '0;
            prev_d     = '0;
            hdr_left_d = '0;
          end else begin
            chain_d    = dec;
            prev_d     = cur_cipher_q;
            hdr_left_d = hdr - skip;
          end
        end
      end
      default: state_d = SIdle;
    endcase
    if (start) begin
      state_d = SRun;
      rnd_d   = '0;
      y_d     = start_blk[63:32];
      z_d     = start_blk[31:0];
      sum_d   = SumInit;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      rnd_q       <= '0;
      chain_q     <= '0;
      prev_q      <= '0;
      hdr_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      chain_q     <= chain_d;
      prev_q      <= prev_d;
      hdr_left_q  <= hdr_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    z_q   <= z_d;
    sum_q <= sum_d;
    if (start) begin
      cur_cipher_q <= q_item_i.cipher;
      cur_last_q   <= q_item_i.last;
      cur_first_q  <= q_item_i.first;
    end
    if (fin_load) begin
      out_plain_q <= plain;
      out_bv_q    <= bv;
      out_eom_q   <= cur_last_q;
      out_st_q    <= st;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.plain_bytes    = out_plain_q;
  assign res_o.byte_valid     = out_bv_q;
  assign res_o.end_of_message = out_eom_q;
  assign res_o.status         = out_st_q;

  `TCBD_ASSERT(a_err_no_bytes, !out_valid_q || (out_st_q == StOk) || (out_bv_q == '0),
               "errored result carries valid bytes")
  `TCBD_ASSERT(a_no_pop_in_run, !q_pop_o || (state_q != SRun), "block taken mid decipher")
  `TCBD_ASSERT_NEXT(a_chain_clear, fin_load && cur_last_q,
                    (chain_q == '0) && (prev_q == '0) && (hdr_left_q == '0),
                    "chain state not cleared after message end")

endmodule

[hw/rtl/tea16_chained_block_decrypt_top.sv]
// top level of the chained 16-round tea block decrypt
//
// channel   dir  payload                                          transfer when
// blk_i     in   cipher_block[63:0], last_block                   valid && ready
// res_o     out  plain_bytes[63:0], byte_valid[7:0], eom, status  valid && ready
// cfg       in   cfg_index_i[1:0], cfg_wdata_i[31:0]              cfg_we_i
//
// a block runs one round per cycle in the decipher unit, then passes a finish state
// that classifies, writes the result and starts the next block if one is queued
// the two-entry input queue keeps taking blocks while the unit is busy, until it is full
// a result waiting in the output register stalls only the finish state
// reset clears the queue, chain state and key words; no clearing pass
module tea16_chained_block_decrypt_top import tcbd_pkg::*; #(
  parameter int unsigned ROUNDS = TcbdRounds
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcbd_in_if.sink     blk_i,
  tcbd_out_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  // key words; the user must write them only while the block is idle, the block itself does not enforce it
  key_t key_q, key_d;

  // queue between front and back
  logic q_valid;
  blk_t q_item;
  logic q_pop;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgKeyWord0: key_d.w0 = cfg_wdata_i;
        CfgKeyWord1: key_d.w1 = cfg_wdata_i;
        CfgKeyWord2: key_d.w2 = cfg_wdata_i;
        CfgKeyWord3: key_d.w3 = cfg_wdata_i;
        default:     key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // front: takes blocks, flags the first block of each message
  tcbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .blk_i     (blk_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back: decipher rounds, chaining, header skip and padding check
  tcbd_back #(
    .ROUNDS (ROUNDS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_i     (key_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

[tb/tb_tea16_chained_block_decrypt_top.sv]
// testbench of the chained 16-round tea block decrypt: directed and random messages
`timescale 1ns / 1ps

module tb_tea16_chained_block_decrypt_top;
  import tcbd_pkg::*;

  // one expected plaintext result
  typedef struct packed {
    logic [63:0] plain;
    logic [7:0]  byte_mask;
    logic        eom;
    status_e     status;
  } plain_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  tcbd_in_if  blk_if ();
  tcbd_out_if res_if ();

  tea16_chained_block_decrypt_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .blk_i      (blk_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  // predictor copy of the key and the chaining state
  logic [31:0]   key_words [4];
  logic [63:0]   chain_dec;
  logic [63:0]   prev_cipher;
  logic [3:0]    hdr_left;
  logic          in_msg;
  plain_result_t expected_plain [$];

  // idling knobs, percent of cycles
  int unsigned sender_idle_pct;
  int unsigned rcv_stall_pct;

  int unsigned blocks_sent;
  int unsigned results_seen;
  int unsigned plain_errors;
  int unsigned count_ok;
  int unsigned count_short;
  int unsigned count_badpad;
  int unsigned key_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("tea16_chained_block_decrypt_top verification failed");
    $finish;
  end

  // tea decipher, one round pair per iteration, sum counting down from delta * rounds
  function automatic logic [63:0] tea_decipher(input logic [63:0] blk);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    y   = blk[63:32];
    z   = blk[31:0];
    sum = TeaDelta * TcbdRounds;
    for (int r = 0; r < TcbdRounds; r++) begin
      z   -= ((y << 4) + key_words[2]) ^ (y + sum) ^ ((y >> 5) + key_words[3]);
      y   -= ((z << 4) + key_words[0]) ^ (z + sum) ^ ((z >> 5) + key_words[1]);
      sum -= TeaDelta;
    end
    return {y, z};
  endfunction

  // forward cipher, used to build well-formed messages
  function automatic logic [63:0] tea_encipher(input logic [63:0] blk);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    y   = blk[63:32];
    z   = blk[31:0];
    sum = '0;
    for (int r = 0; r < TcbdRounds; r++) begin
      sum += TeaDelta;
      y   += ((z << 4) + key_words[0]) ^ (z + sum) ^ ((z >> 5) + key_words[1]);
      z   += ((y << 4) + key_words[2]) ^ (y + sum) ^ ((y >> 5) + key_words[3]);
    end
    return {y, z};
  endfunction

  // expected result of one accepted cipher block, then chain state update
  function automatic void predict_plaintext(input logic [63:0] cipher, input logic last);
    logic [63:0]   dec;
    logic [63:0]   plain;
    logic [3:0]    hdr;
    logic [3:0]    skip;
    logic [7:0]    mask;
    status_e       st;
    plain_result_t res;
    dec   = tea_decipher(cipher ^ chain_dec);
    plain = dec ^ prev_cipher;
    // first block: pad length from byte 0 plus the fixed header
    hdr   = in_msg ? hdr_left : {1'b0, plain[58:56]} + HeaderFixed;
    skip  = (hdr > BlockBytes) ? BlockBytes : hdr;
    mask  = 8'hFF >> skip;
    st    = StOk;
    if (last) begin
      // only byte 0 of the last block may carry plaintext
      mask &= 8'h80;
      if (!in_msg || skip > 4'd1) begin
        st = StShort;
      end else if (plain[55:0] != '0) begin
        st = StBadPad;
      end
    end
    if (st != StOk) begin
      mask = '0;
    end
    res.plain     = plain;
    res.byte_mask = mask;
    res.eom       = last;
    res.status    = st;
    expected_plain.push_back(res);
    if (last) begin
      chain_dec   = '0;
      prev_cipher = '0;
      hdr_left    = '0;
      in_msg      = 1'b0;
    end else begin
      chain_dec   = dec;
      prev_cipher = cipher;
      hdr_left    = hdr - skip;
      in_msg      = 1'b1;
    end
  endfunction

  // one register write; the caller lowers the enable after its last write
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    key_words[idx] = data;
    @(posedge clk);
  endtask

  task automatic write_key(input key_t key);
    cfg_write(CfgKeyWord0, key.w0);
    cfg_write(CfgKeyWord1, key.w1);
    cfg_write(CfgKeyWord2, key.w2);
    cfg_write(CfgKeyWord3, key.w3);
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  // valid stays high between back-to-back blocks; it drops only in a gap or a drain
  task automatic send_block(input logic [63:0] cipher, input logic last);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      blk_if.valid <= 1'b0;
      @(posedge clk);
    end
    blk_if.valid        <= 1'b1;
    blk_if.cipher_block <= cipher;
    blk_if.last_block   <= last;
    @(posedge clk);
    while (!blk_if.ready) @(posedge clk);
    predict_plaintext(cipher, last);
    blocks_sent++;
  endtask

  // builds a message from chosen plaintext and sends it in chained form;
  // bad_trail puts nonzero bytes in the trailing padding
  task automatic send_message(input int unsigned nblk, input logic [2:0] pad,
                              input bit bad_trail);
    logic [63:0] pb;
    logic [63:0] dec;
    logic [63:0] c_prev;
    logic [63:0] dec_prev;
    logic [63:0] cipher;
    c_prev   = '0;
    dec_prev = '0;
    for (int unsigned k = 0; k < nblk; k++) begin
      pb = {$urandom, $urandom};
      if (k == 0) begin
        pb[58:56] = pad;
      end
      if (k == nblk - 1) begin
        pb[55:0] = bad_trail ? (56'(pb) | (56'd1 << $urandom_range(55))) : '0;
      end
      dec      = pb ^ c_prev;
      cipher   = tea_encipher(dec) ^ dec_prev;
      dec_prev = dec;
      c_prev   = cipher;
      send_block(cipher, k == nblk - 1);
    end
  endtask

  task automatic wait_for_results();
    blk_if.valid <= 1'b0;
    while (expected_plain.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls and the field-by-field check
  initial begin : result_sink
    plain_result_t want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        results_seen++;
        case (res_if.status)
          StOk:     count_ok++;
          StShort:  count_short++;
          StBadPad: count_badpad++;
          default:  ;
        endcase
        if (expected_plain.size() == 0) begin
          plain_errors++;
          if (plain_errors <= 10) begin
            $display("unexpected result: plain %h mask %h eom %b status %0d",
                     res_if.plain_bytes, res_if.byte_valid, res_if.end_of_message,
                     res_if.status);
          end
        end else begin
          want = expected_plain.pop_front();
          if (res_if.plain_bytes !== want.plain || res_if.byte_valid !== want.byte_mask ||
              res_if.end_of_message !== want.eom || res_if.status !== want.status) begin
            plain_errors++;
            if (plain_errors <= 10) begin
              $display("mismatch at %0t: exp plain %h mask %h eom %b status %0d", $realtime,
                       want.plain, want.byte_mask, want.eom, want.status);
              $display("                   got plain %h mask %h eom %b status %0d",
                       res_if.plain_bytes, res_if.byte_valid, res_if.end_of_message,
                       res_if.status);
            end
          end
        end
      end
      res_if.ready <= !(rcv_stall_pct != 0 && $urandom_range(99) < rcv_stall_pct);
    end
  end

  // key left at its reset value of zero
  task automatic test_reset_key_message();
    send_message(2, 3'd1, 1'b0);
    wait_for_results();
  endtask

  // pad length extremes, header boundary, short messages, bad padding, raw extremes
  task automatic test_header_and_padding();
    write_key('{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210});
    send_block(64'h0, 1'b0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // single block message is always too short
    send_message(1, 3'd5, 1'b0);
    send_message(2, 3'd0, 1'b0);
    send_message(2, 3'd3, 1'b0);
    // header ends exactly on byte 0 of the last block
    send_message(2, 3'd6, 1'b0);
    // header reaches past byte 0 of the last block
    send_message(2, 3'd7, 1'b0);
    // longest pad with room to spare
    send_message(3, 3'd7, 1'b0);
    send_message(2, 3'd2, 1'b1);
    wait_for_results();
  endtask

  // a key word written between blocks of one message applies to the next block
  task automatic test_key_change_mid_message();
    write_key('{$urandom, $urandom, $urandom, $urandom});
    send_block({$urandom, $urandom}, 1'b0);
    send_block({$urandom, $urandom}, 1'b0);
    wait_for_results();
    cfg_write(CfgKeyWord2, $urandom);
    cfg_we <= 1'b0;
    send_block({$urandom, $urandom}, 1'b0);
    send_block({$urandom, $urandom}, 1'b1);
    wait_for_results();
  endtask

  // mostly well-formed messages with random content, some raw noise bursts
  task automatic test_random_traffic(input key_t key, input int unsigned idle_pct,
                                     input int unsigned stall_pct, input int unsigned items);
    int unsigned sent;
    int unsigned nblk;
    sent = 0;
    write_key(key);
    sender_idle_pct = idle_pct;
    rcv_stall_pct   = stall_pct;
    while (sent < items) begin
      if ($urandom_range(99) < 80) begin
        nblk = ($urandom_range(9) == 0) ? $urandom_range(1, 10) : $urandom_range(2, 4);
        send_message(nblk, 3'($urandom_range(7)), $urandom_range(9) == 0);
      end else begin
        nblk = $urandom_range(1, 3);
        for (int unsigned k = 0; k < nblk; k++) begin
          send_block({$urandom, $urandom}, (k == nblk - 1) && ($urandom_range(99) < 85));
        end
      end
      sent += nblk;
    end
    wait_for_results();
    sender_idle_pct = 0;
    rcv_stall_pct   = 0;
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CfgKeyWord0;
    cfg_wdata           <= '0;
    blk_if.valid        <= 1'b0;
    blk_if.cipher_block <= '0;
    blk_if.last_block   <= 1'b0;
    sender_idle_pct = 0;
    rcv_stall_pct   = 0;
    blocks_sent     = 0;
    results_seen    = 0;
    plain_errors    = 0;
    count_ok        = 0;
    count_short     = 0;
    count_badpad    = 0;
    key_settings    = 0;
    for (int i = 0; i < 4; i++) begin
      key_words[i] = '0;
    end
    chain_dec   = '0;
    prev_cipher = '0;
    hdr_left    = '0;
    in_msg      = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key_message();
    test_header_and_padding();
    test_key_change_mid_message();
    // idling phases: none, sender gaps, receiver stalls, both
    test_random_traffic('{$urandom, $urandom, $urandom, $urandom}, 0, 0, 160);
    test_random_traffic('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                        46, 0, 160);
    test_random_traffic('{32'h0, 32'h0, 32'h0, 32'h0}, 0, 46, 160);
    test_random_traffic('{$urandom, $urandom, $urandom, $urandom}, 21, 21, 160);

    // pipeline settles: nothing more may come out
    repeat (TcbdRounds + 8) @(posedge clk);

    $display("sent %0d cipher blocks, checked %0d results: %0d ok, %0d too short, %0d bad pad",
             blocks_sent, results_seen, count_ok, count_short, count_badpad);
    $display("%0d key settings, four idle/stall mixes, %0d errors",
             key_settings, plain_errors);
    if (plain_errors == 0 && expected_plain.size() == 0) begin
      $display("tea16_chained_block_decrypt_top verification clean");
    end else begin
      $display("tea16_chained_block_decrypt_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tcbd_pkg.sv
hw/rtl/tcbd_in_if.sv
hw/rtl/tcbd_out_if.sv
hw/rtl/tcbd_front.sv
hw/rtl/tcbd_back.sv
hw/rtl/tea16_chained_block_decrypt_top.sv
tb/tb_tea16_chained_block_decrypt_top.sv
